/* rtl/flash_save_command_sequencer_top_macros.svh */
// Assertion macros for the checker file of this block.
`ifndef FLASH_SAVE_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define FLASH_SAVE_COMMAND_SEQUENCER_TOP_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define FSCS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication from a trigger to a consequence in the same cycle.
`define FSCS_ASSERT_IMPL(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/fscs_pkg.sv */
package fscs_pkg;

    localparam int unsigned MEM_BYTES_DEF    = 131072;
    localparam int unsigned SECTOR_BYTES_DEF = 32'h1000;
    localparam int unsigned BANK_BYTES_DEF   = 32'h10000;

    localparam logic [15:0] OFS_UNLOCK1 = 16'h5555;
    localparam logic [15:0] OFS_UNLOCK2 = 16'h2AAA;

    localparam logic [7:0] CMD_NONE         = 8'h00;
    localparam logic [7:0] CMD_UNLOCK_A     = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK_B     = 8'h55;
    localparam logic [7:0] CMD_BANK         = 8'hB0;
    localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0] CMD_ID           = 8'h90;
    localparam logic [7:0] CMD_ERASE        = 8'h80;
    localparam logic [7:0] CMD_ERASE_SECTOR = 8'h30;
    localparam logic [7:0] CMD_RESET        = 8'hF0;
    localparam logic [7:0] BYTE_BLANK       = 8'hFF;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_U1,
        SEQ_U2,
        SEQ_E0,
        SEQ_E1,
        SEQ_E2,
        SEQ_I0,
        SEQ_I1,
        SEQ_I2
    } seq_state_t;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_SAVE_PRESENT = 2'd0,
        CFG_FLASH_MODE   = 2'd1,
        CFG_ID_MANUF     = 2'd2,
        CFG_ID_DEVICE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

/* rtl/fscs_mem.sv */
module fscs_mem #(
    parameter int unsigned DEPTH = fscs_pkg::MEM_BYTES_DEF,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic                clk,
    input  fscs_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       waddr,
    input  logic [7:0]          wdata,
    input  logic [AW-1:0]       raddr,
    output logic [7:0]          rdata
);
    import fscs_pkg::*;

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fscs_ctrl.sv */
module fscs_ctrl #(
    parameter int unsigned MEM_BYTES    = fscs_pkg::MEM_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = fscs_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BANK_BYTES   = fscs_pkg::BANK_BYTES_DEF,
    localparam int unsigned AW = $clog2(MEM_BYTES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                op,
    input  logic [15:0]         offset,
    input  logic [7:0]          write_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output logic                busy,
    output logic                done,
    output logic [7:0]          read_data,
    output fscs_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]       mem_waddr,
    output logic [7:0]          mem_wdata,
    output logic [AW-1:0]       mem_raddr,
    input  logic [7:0]          mem_rdata
);
    import fscs_pkg::*;

    localparam int unsigned BANK_W = $clog2(BANK_BYTES);
    localparam int unsigned SW     = $clog2(SECTOR_BYTES);
    localparam int unsigned FULL_W = 8 + BANK_W;
    localparam int unsigned XW     = (FULL_W > AW) ? FULL_W : AW;

    logic       save_present_reg;
    logic       flash_mode_reg;
    logic [7:0] id_manuf_reg;
    logic [7:0] id_device_reg;

    seq_state_t seq_reg, seq_next;
    logic [7:0] pend_reg, pend_next;
    logic [7:0] bank_reg, bank_next;

    logic          done_reg;
    logic          use_mem_reg, use_mem_next;
    logic [7:0]    const_reg, const_next;

    logic          erase_active_reg;
    logic          erase_ok_reg;
    logic [AW-1:0] erase_base_reg;
    logic [SW-1:0] erase_cnt_reg;

    logic          accept;
    logic          fall_through;
    logic          prog;
    logic          erase_go;
    logic          rd_mem;
    logic [AW-1:0] rd_addr;
    logic [XW-1:0] bank_full;
    logic [AW-1:0] bank_idx;
    logic          bank_in_range;

    assign accept        = start && !erase_active_reg;
    assign bank_full     = XW'({bank_reg, offset[BANK_W-1:0]});
    assign bank_idx      = bank_full[AW-1:0];
    assign bank_in_range = (bank_full >> AW) == '0;

    always_comb
    begin
        seq_next     = seq_reg;
        pend_next    = pend_reg;
        bank_next    = bank_reg;
        fall_through = 1'b0;
        prog         = 1'b0;
        erase_go     = 1'b0;
        rd_mem       = 1'b0;
        rd_addr      = bank_idx;
        use_mem_next = 1'b0;
        const_next   = BYTE_BLANK;
        if (accept && save_present_reg)
        begin
            if (op == OP_WRITE)
            begin
                if (flash_mode_reg)
                begin
                    unique case (seq_reg)
                        SEQ_IDLE:
                        begin
                            if (offset == OFS_UNLOCK1 && write_data == CMD_RESET)
                            begin
                                pend_next = CMD_NONE;
                            end
                            else if (offset == OFS_UNLOCK1 && write_data == CMD_UNLOCK_A)
                            begin
                                seq_next = SEQ_U1;
                            end
                            else if (offset == '0 && pend_reg == CMD_BANK)
                            begin
                                bank_next = write_data;
                                pend_next = CMD_NONE;
                            end
                            else
                            begin
                                fall_through = 1'b1;
                            end
                        end
                        SEQ_U1, SEQ_E1, SEQ_I1:
                        begin
                            if (offset == OFS_UNLOCK2 && write_data == CMD_UNLOCK_B)
                            begin
                                seq_next = (seq_reg == SEQ_U1) ? SEQ_U2 :
                                           (seq_reg == SEQ_E1) ? SEQ_E2 : SEQ_I2;
                            end
                            else
                            begin
                                seq_next     = SEQ_IDLE;
                                fall_through = 1'b1;
                            end
                        end
                        SEQ_U2:
                        begin
                            if (offset == OFS_UNLOCK1)
                            begin
                                seq_next  = (write_data == CMD_ERASE) ? SEQ_E0 :
                                            (write_data == CMD_ID) ? SEQ_I0 : SEQ_IDLE;
                                pend_next = write_data;
                            end
                            else
                            begin
                                seq_next     = SEQ_IDLE;
                                fall_through = 1'b1;
                            end
                        end
                        SEQ_E0, SEQ_I0:
                        begin
                            if (offset == OFS_UNLOCK1 && write_data == CMD_UNLOCK_A)
                            begin
                                seq_next = (seq_reg == SEQ_E0) ? SEQ_E1 : SEQ_I1;
                            end
                            else
                            begin
                                seq_next     = SEQ_IDLE;
                                fall_through = 1'b1;
                            end
                        end
                        SEQ_E2:
                        begin
                            erase_go  = (write_data == CMD_ERASE_SECTOR);
                            seq_next  = SEQ_IDLE;
                            pend_next = CMD_NONE;
                        end
                        SEQ_I2:
                        begin
                            seq_next  = SEQ_IDLE;
                            pend_next = CMD_NONE;
                        end
                        default:
                        begin
                            seq_next     = SEQ_IDLE;
                            fall_through = 1'b1;
                        end
                    endcase
                    if (fall_through && pend_reg == CMD_PROGRAM)
                    begin
                        prog      = 1'b1;
                        seq_next  = SEQ_IDLE;
                        pend_next = CMD_NONE;
                    end
                end
            end
            else if (flash_mode_reg)
            begin
                if (pend_reg == CMD_NONE)
                begin
                    rd_mem       = bank_in_range;
                    use_mem_next = bank_in_range;
                end
                else if (pend_reg == CMD_ID)
                begin
                    if (offset == 16'd0)
                    begin
                        const_next = id_manuf_reg;
                    end
                    else if (offset == 16'd1)
                    begin
                        const_next = id_device_reg;
                    end
                end
                else if (pend_reg == CMD_RESET)
                begin
                    seq_next  = SEQ_IDLE;
                    pend_next = CMD_NONE;
                end
            end
            else
            begin
                rd_mem       = 1'b1;
                rd_addr      = AW'(offset);
                use_mem_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_IDLE;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            save_present_reg <= 1'b1;
            flash_mode_reg   <= 1'b1;
            id_manuf_reg     <= 8'h32;
            id_device_reg    <= 8'h1B;
            pend_reg         <= CMD_NONE;
            bank_reg         <= 8'h00;
            done_reg         <= 1'b0;
            use_mem_reg      <= 1'b0;
            erase_active_reg <= 1'b0;
            erase_ok_reg     <= 1'b0;
            erase_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_SAVE_PRESENT: save_present_reg <= cfg_data[0];
                    CFG_FLASH_MODE:   flash_mode_reg   <= cfg_data[0];
                    CFG_ID_MANUF:     id_manuf_reg     <= cfg_data;
                    CFG_ID_DEVICE:    id_device_reg    <= cfg_data;
                    default:          ;
                endcase
            end
            pend_reg    <= pend_next;
            bank_reg    <= bank_next;
            done_reg    <= accept;
            use_mem_reg <= use_mem_next;
            if (erase_active_reg)
            begin
                erase_cnt_reg <= erase_cnt_reg + 1'b1;
                if (erase_cnt_reg == '1)
                begin
                    erase_active_reg <= 1'b0;
                end
            end
            else if (erase_go)
            begin
                erase_active_reg <= 1'b1;
                erase_ok_reg     <= bank_in_range;
                erase_cnt_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        const_reg <= const_next;
        if (erase_go && !erase_active_reg)
        begin
            erase_base_reg <= bank_idx & ~AW'(SECTOR_BYTES - 1);
        end
    end

    always_comb
    begin
        mem_ctl.rd_en = rd_mem;
        if (erase_active_reg)
        begin
            mem_ctl.wr_en = erase_ok_reg;
            mem_waddr     = erase_base_reg | AW'(erase_cnt_reg);
            mem_wdata     = BYTE_BLANK;
        end
        else
        begin
            mem_ctl.wr_en = prog && bank_in_range;
            mem_waddr     = bank_idx;
            mem_wdata     = write_data;
        end
    end

    assign mem_raddr = rd_addr;
    assign busy      = erase_active_reg;
    assign done      = done_reg;
    assign read_data = use_mem_reg ? mem_rdata : const_reg;

endmodule

/* rtl/flash_save_command_sequencer_top.sv */
// The result of a transfer taken at one clock edge shows on read_data with done in the
// cycle after it; the receiver cannot stall.
// One transfer is taken per cycle, except that a sector erase holds busy high, and start is
// ignored, while its write port sweeps the sector with 0xFF, one byte a cycle.
// Reset (rst_n, asynchronous, active low) returns the sequencer, the pending command, the
// bank and the config registers to their reset values; the save memory is not cleared.
module flash_save_command_sequencer_top #(
    parameter int unsigned MEM_BYTES    = fscs_pkg::MEM_BYTES_DEF,
    parameter int unsigned SECTOR_BYTES = fscs_pkg::SECTOR_BYTES_DEF,
    parameter int unsigned BANK_BYTES   = fscs_pkg::BANK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [15:0] offset,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic [7:0]  read_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import fscs_pkg::*;

    localparam int unsigned AW = $clog2(MEM_BYTES);

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    fscs_ctrl #(
        .MEM_BYTES    (MEM_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BANK_BYTES   (BANK_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .offset     (offset),
        .write_data (write_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .busy       (busy),
        .done       (done),
        .read_data  (read_data),
        .mem_ctl    (mem_ctl),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    fscs_mem #(
        .DEPTH (MEM_BYTES)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* rtl/fscs_checker.sv */
`include "flash_save_command_sequencer_top_macros.svh"

module fscs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        op,
    input logic        done,
    input logic [7:0]  read_data
);
    import fscs_pkg::*;

    `FSCS_ASSERT_CLK(a_result_follows, start && !busy |=> done, "accepted transfer gave no result")
    `FSCS_ASSERT_CLK(a_no_spurious, done |-> $past(start && !busy), "result without a transfer")
    `FSCS_ASSERT_IMPL(a_write_blank, done && $past(op), read_data == BYTE_BLANK, "write not blank")
    `FSCS_ASSERT_IMPL(a_erase_result, $rose(busy), done, "erase began without its result")

endmodule

bind flash_save_command_sequencer_top fscs_checker u_fscs_checker (.*);
